### design/txcw_pkg.sv
package txcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [7:0] NEWLINE_CODE  = 8'd10;
  localparam logic [7:0] SPACE_CODE    = 8'd32;
  localparam logic [7:0] ATTR_RESET    = 8'd7;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
    logic       place;
    logic [6:0] column;
    logic [4:0] row;
  } item_t;

  typedef struct packed {
    logic [7:0] cell_character;
    logic [7:0] cell_attribute;
    logic [6:0] cursor_column;
    logic [4:0] cursor_row;
    logic       scrolled;
  } result_t;

  typedef enum logic [2:0] {
    WR_NONE = 3'd0,
    WR_PUT  = 3'd1,
    WR_INIT = 3'd2,
    WR_FILL = 3'd3,
    WR_COPY = 3'd4,
    WR_ZERO = 3'd5
  } wr_mode_t;

  typedef struct packed {
    logic     accept;
    logic     advance;
    logic     capture;
    logic     rd_copy;
    logic     home;
    logic     mark_scroll;
    wr_mode_t wr_mode;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic need_scroll;
    logic sweep_last;
    logic copy_last;
  } dp_status_t;

endpackage

### design/txcw_ram.sv
module txcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/txcw_datapath.sv
module txcw_datapath import txcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  item_t      item,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output result_t    result
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] LAST_START = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLUMNS - 1);
  localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);

  logic [7:0]    default_attr;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [AW-1:0] sweep;
  op_t           op;
  logic [7:0]    ch;
  logic          rd_valid;
  logic [7:0]    cell_char;
  logic [7:0]    cell_attr;
  logic          scrolled;

  logic [AW-1:0] item_addr;
  logic [AW-1:0] put_addr;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          char_we;
  logic          attr_we;
  logic [7:0]    char_wdata;
  logic [7:0]    attr_wdata;
  logic [7:0]    char_rdata;
  logic [7:0]    attr_rdata;
  logic          item_in_range;
  logic          col_over;
  logic          row_over;
  logic          is_newline;
  logic          row_end;

  assign item_addr  = AW'(AW'(item.row) * COLS_A + AW'(item.column));
  assign put_addr   = AW'(AW'(cur_row) * COLS_A + AW'(cur_col));
  assign col_over   = 32'(item.column) >= 32'(COLUMNS);
  assign row_over   = 32'(item.row) >= 32'(ROWS);
  assign item_in_range = !col_over && !row_over;
  assign is_newline = (ch == NEWLINE_CODE);
  assign row_end    = is_newline || (cur_col == LAST_COL);
  assign raddr      = cmd.rd_copy ? AW'(sweep + COLS_A) : item_addr;

  assign status.op          = op;
  assign status.need_scroll = row_end && (cur_row == LAST_ROW);
  assign status.sweep_last  = (sweep == LAST_CELL);
  assign status.copy_last   = (sweep == COPY_LAST);

  always_comb begin
    waddr      = sweep;
    char_we    = 1'b0;
    attr_we    = 1'b0;
    char_wdata = 8'd0;
    attr_wdata = 8'd0;
    case (cmd.wr_mode)
      WR_PUT: begin
        waddr      = put_addr;
        char_we    = !is_newline;
        attr_we    = !is_newline;
        char_wdata = ch;
        attr_wdata = default_attr;
      end
      WR_INIT: begin
        char_we = 1'b1;
        attr_we = 1'b1;
      end
      WR_FILL: begin
        char_we    = 1'b1;
        attr_we    = 1'b1;
        char_wdata = (sweep >= LAST_START) ? 8'd0 : SPACE_CODE;
        attr_wdata = default_attr;
      end
      WR_COPY: begin
        char_we    = 1'b1;
        attr_we    = 1'b1;
        char_wdata = char_rdata;
        attr_wdata = attr_rdata;
      end
      WR_ZERO: begin
        char_we = 1'b1;
      end
      default: begin
        char_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= ATTR_RESET;
      cur_col      <= '0;
      cur_row      <= '0;
      sweep        <= '0;
    end else begin
      if (cfg_valid) begin
        default_attr <= cfg_data;
      end
      if (cmd.accept) begin
        sweep <= '0;
      end else if (cmd.wr_mode inside {WR_INIT, WR_FILL, WR_COPY, WR_ZERO}) begin
        sweep <= AW'(sweep + 1'b1);
      end
      if (cmd.accept && op_t'(item.operation) == OP_PUT && item.place) begin
        cur_col <= col_over ? LAST_COL : CW'(item.column);
        cur_row <= row_over ? LAST_ROW : RW'(item.row);
      end else if (cmd.advance) begin
        if (row_end) begin
          cur_col <= '0;
          if (cur_row != LAST_ROW) begin
            cur_row <= RW'(cur_row + 1'b1);
          end
        end else begin
          cur_col <= CW'(cur_col + 1'b1);
        end
      end else if (cmd.home) begin
        cur_col <= '0;
        cur_row <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op        <= op_t'(item.operation);
      ch        <= item.character;
      rd_valid  <= item_in_range;
      cell_char <= 8'd0;
      cell_attr <= 8'd0;
      scrolled  <= 1'b0;
    end else begin
      if (cmd.capture && rd_valid) begin
        cell_char <= char_rdata;
        cell_attr <= attr_rdata;
      end
      if (cmd.home || cmd.mark_scroll) begin
        scrolled <= 1'b1;
      end
    end
  end

  txcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (waddr),
    .wdata (char_wdata),
    .raddr (raddr),
    .rdata (char_rdata)
  );

  txcw_ram #(.WIDTH(8), .DEPTH(CELLS)) u_attr_ram (
    .clk   (clk),
    .we    (attr_we),
    .waddr (waddr),
    .wdata (attr_wdata),
    .raddr (raddr),
    .rdata (attr_rdata)
  );

  assign result.cell_character = cell_char;
  assign result.cell_attribute = cell_attr;
  assign result.cursor_column  = 7'(cur_col);
  assign result.cursor_row     = 5'(cur_row);
  assign result.scrolled       = scrolled;

endmodule

### design/txcw_ctrl.sv
module txcw_ctrl import txcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  dp_status_t status,
  output dp_cmd_t    cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [7:0] {
    ST_INIT    = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_EXEC    = 8'b0000_0100,
    ST_FILL    = 8'b0000_1000,
    ST_COPY_RD = 8'b0001_0000,
    ST_COPY_WR = 8'b0010_0000,
    ST_ZERO    = 8'b0100_0000,
    ST_DONE    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = !(state inside {ST_IDLE, ST_DONE});
  assign done = (state == ST_DONE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.wr_mode = WR_NONE;
    case (state)
      ST_INIT: begin
        cmd.wr_mode = WR_INIT;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE, ST_DONE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EXEC: begin
        case (status.op)
          OP_PUT: begin
            cmd.wr_mode = WR_PUT;
            cmd.advance = 1'b1;
            state_next  = status.need_scroll ? ST_COPY_RD : ST_DONE;
          end
          OP_CLEAR: begin
            state_next = ST_FILL;
          end
          OP_READ: begin
            cmd.capture = 1'b1;
            state_next  = ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_FILL: begin
        cmd.wr_mode = WR_FILL;
        if (status.sweep_last) begin
          cmd.home   = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_COPY_RD: begin
        cmd.rd_copy = 1'b1;
        state_next  = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd.wr_mode = WR_COPY;
        state_next  = status.copy_last ? ST_ZERO : ST_COPY_RD;
      end
      ST_ZERO: begin
        cmd.wr_mode = WR_ZERO;
        if (status.sweep_last) begin
          cmd.mark_scroll = 1'b1;
          state_next      = ST_DONE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/text_console_writer_unit.sv
// Put, read and unused codes: the item is taken in IDLE or DONE, run in EXEC, and done is raised in DONE;
// a new start is taken while done is shown. Put that scrolls: each cell copy is a read in COPY_RD followed
// by a write in COPY_WR through the single write port of the cell memories.
// Clear: one cell written per cycle.
// After reset busy stays high while the cell memories are zeroed;
// configuration writes are taken at any time. Results cannot be stalled.
module text_console_writer_unit import txcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  item_t      item,
  output logic       done,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  txcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  txcw_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

### sim/text_console_writer_unit_tb.sv
module text_console_writer_unit_tb import txcw_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS       = COLUMNS_DEF * ROWS_DEF;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 370;
  localparam int STEPS       = 19;

  typedef struct packed {
    item_t   stim;
    logic    typed;
    result_t want;
  } step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  item_t      item = '0;
  logic       done;
  result_t    result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  logic [7:0] shadow_char [CELLS] = '{default: 8'h00};
  logic [7:0] shadow_attr [CELLS] = '{default: 8'h00};
  int         shadow_cursor = 0;
  logic [7:0] shadow_attr_default = ATTR_RESET;

  result_t report_q [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  bit      pacing = 1'b1;

  step_t steps [STEPS] = '{
    '{'{OP_READ,  8'h00, 1'b0, 7'd0,   5'd0},  1'b1, '{8'h00, 8'h00, 7'd0,  5'd0,  1'b0}},
    '{'{OP_PUT,   8'h41, 1'b0, 7'd0,   5'd0},  1'b1, '{8'h00, 8'h00, 7'd1,  5'd0,  1'b0}},
    '{'{OP_READ,  8'h00, 1'b0, 7'd0,   5'd0},  1'b1, '{8'h41, 8'h07, 7'd1,  5'd0,  1'b0}},
    '{'{OP_PUT,   8'hFF, 1'b1, 7'd127, 5'd31}, 1'b1, '{8'h00, 8'h00, 7'd0,  5'd24, 1'b1}},
    '{'{OP_READ,  8'h00, 1'b0, 7'd79,  5'd23}, 1'b1, '{8'hFF, 8'h07, 7'd0,  5'd24, 1'b0}},
    '{'{OP_READ,  8'hFF, 1'b1, 7'd127, 5'd31}, 1'b1, '{8'h00, 8'h00, 7'd0,  5'd24, 1'b0}},
    '{'{OP_READ,  8'h00, 1'b0, 7'd79,  5'd24}, 1'b1, '{8'h00, 8'h07, 7'd0,  5'd24, 1'b0}},
    '{'{OP_PUT,   NEWLINE_CODE, 1'b0, 7'd0, 5'd0}, 1'b1, '{8'h00, 8'h00, 7'd0, 5'd24, 1'b1}},
    '{'{OP_NONE,  8'hFF, 1'b1, 7'd127, 5'd31}, 1'b1, '{8'h00, 8'h00, 7'd0,  5'd24, 1'b0}},
    '{'{OP_PUT,   8'h00, 1'b1, 7'd5,   5'd3},  1'b0, '0},
    '{'{OP_PUT,   8'h7F, 1'b1, 7'd79,  5'd0},  1'b0, '0},
    '{'{OP_PUT,   NEWLINE_CODE, 1'b1, 7'd79, 5'd0}, 1'b0, '0},
    '{'{OP_PUT,   8'h80, 1'b1, 7'd0,   5'd24}, 1'b0, '0},
    '{'{OP_READ,  8'h00, 1'b0, 7'd5,   5'd3},  1'b0, '0},
    '{'{OP_READ,  8'h00, 1'b0, 7'd0,   5'd24}, 1'b0, '0},
    '{'{OP_CLEAR, 8'hFF, 1'b1, 7'd10,  5'd10}, 1'b1, '{8'h00, 8'h00, 7'd0,  5'd0,  1'b1}},
    '{'{OP_READ,  8'h00, 1'b0, 7'd0,   5'd0},  1'b1, '{8'h20, 8'h07, 7'd0,  5'd0,  1'b0}},
    '{'{OP_READ,  8'h00, 1'b0, 7'd79,  5'd23}, 1'b1, '{8'h20, 8'h07, 7'd0,  5'd0,  1'b0}},
    '{'{OP_READ,  8'h00, 1'b0, 7'd79,  5'd24}, 1'b1, '{8'h00, 8'h07, 7'd0,  5'd0,  1'b0}}
  };

  text_console_writer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic write_at_cursor(logic [7:0] ch);
    int pos;
    pos = shadow_cursor;
    if (ch == NEWLINE_CODE) begin
      pos = (pos / COLUMNS_DEF) * COLUMNS_DEF + COLUMNS_DEF - 1;
    end else begin
      shadow_char[pos] = ch;
      shadow_attr[pos] = shadow_attr_default;
    end
    pos++;
    if (pos >= CELLS) begin
      for (int i = 0; i < CELLS - COLUMNS_DEF; i++) begin
        shadow_char[i] = shadow_char[i + COLUMNS_DEF];
        shadow_attr[i] = shadow_attr[i + COLUMNS_DEF];
      end
      for (int i = CELLS - COLUMNS_DEF; i < CELLS; i++) shadow_char[i] = 8'h00;
      shadow_cursor = pos - COLUMNS_DEF;
      return 1'b1;
    end
    shadow_cursor = pos;
    return 1'b0;
  endfunction

  function automatic result_t emulate_console(item_t it);
    result_t r;
    int      col;
    int      row;
    int      idx;
    r = '0;
    case (op_t'(it.operation))
      OP_PUT: begin
        if (it.place) begin
          col = (it.column >= COLUMNS_DEF) ? COLUMNS_DEF - 1 : int'(it.column);
          row = (it.row >= ROWS_DEF) ? ROWS_DEF - 1 : int'(it.row);
          shadow_cursor = row * COLUMNS_DEF + col;
        end
        r.scrolled = write_at_cursor(it.character);
      end
      OP_CLEAR: begin
        for (idx = 0; idx < CELLS; idx++) begin
          shadow_cursor = idx;
          if (write_at_cursor(SPACE_CODE)) r.scrolled = 1'b1;
        end
        shadow_cursor = 0;
      end
      OP_READ: begin
        if (it.column < COLUMNS_DEF && it.row < ROWS_DEF) begin
          idx = int'(it.row) * COLUMNS_DEF + int'(it.column);
          r.cell_character = shadow_char[idx];
          r.cell_attribute = shadow_attr[idx];
        end
      end
      default: ;
    endcase
    r.cursor_column = 7'(shadow_cursor % COLUMNS_DEF);
    r.cursor_row    = 5'(shadow_cursor / COLUMNS_DEF);
    return r;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.operation = OP_PUT;
    it.character = 8'($urandom);
    it.place     = 1'($urandom_range(1));
    it.column    = 7'($urandom_range(COLUMNS_DEF - 1));
    it.row       = 5'($urandom_range(ROWS_DEF - 1));
    pick = int'($urandom_range(99));
    if (pick < 2) begin
      it.operation = OP_CLEAR;
    end else if (pick < 4) begin
      it.operation = OP_NONE;
      it.column    = 7'($urandom);
      it.row       = 5'($urandom);
    end else if (pick < 18) begin
      it.operation = OP_READ;
      if ($urandom_range(9) == 0) begin
        it.column = 7'($urandom);
        it.row    = 5'($urandom);
      end
    end else begin
      if ($urandom_range(99) < 6) it.character = NEWLINE_CODE;
      it.place = ($urandom_range(9) == 0);
      pick = int'($urandom_range(9));
      if (pick < 3) begin
        it.column = 7'($urandom_range(COLUMNS_DEF - 1, COLUMNS_DEF - 10));
        it.row    = 5'(ROWS_DEF - 1);
      end else if (pick == 3) begin
        it.column = 7'($urandom);
        it.row    = 5'($urandom);
      end
    end
    return it;
  endfunction

  task automatic send(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    while (pacing && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = emulate_console(it);
    report_q.push_back(typed ? want : predicted);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_attribute(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_attr_default = value;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (report_q.size() == 0) begin
        $display("%0t ns: result with none expected, expected none, got %h", $time, result);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        compare_field("cell_character", int'(want.cell_character),
                      int'(result.cell_character));
        compare_field("cell_attribute", int'(want.cell_attribute),
                      int'(result.cell_attribute));
        compare_field("cursor_column", int'(want.cursor_column),
                      int'(result.cursor_column));
        compare_field("cursor_row", int'(want.cursor_row), int'(result.cursor_row));
        compare_field("scrolled", int'(want.scrolled), int'(result.scrolled));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] attr_plan [PHASES];
    attr_plan[0] = 8'hFF;
    attr_plan[1] = 8'h00;
    attr_plan[2] = 8'($urandom);
    attr_plan[3] = ATTR_RESET;
    attr_plan[4] = 8'($urandom);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < STEPS; i++) send(steps[i].stim, steps[i].typed, steps[i].want);
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_attribute(attr_plan[p]);
      pacing = (p != 2);
      repeat (PHASE_ITEMS) send(random_item(), 1'b0, '0);
    end
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
design/txcw_pkg.sv
design/txcw_ram.sv
design/txcw_datapath.sv
design/txcw_ctrl.sv
design/text_console_writer_unit.sv
sim/text_console_writer_unit_tb.sv
